### rtl/brd_pkg.sv
// ----------------------------------------------------------------------------
// Bounded ring deque package
// Shared widths, operation codes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package brd_pkg;

	localparam int DATA_W         = 32;
	localparam int FUNC_W         = 3;
	localparam int POS_W          = 4;
	localparam int CAP_W          = 5;
	localparam int CNT_W          = 5;
	localparam int S_TDATA_W      = 40;
	localparam int M_TDATA_W      = 104;
	localparam int DEPTH_DEF      = 16;
	localparam int WORD_WIDTH_DEF = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic [FUNC_W-1:0] FN_APPEND    = 3'd0;
	localparam logic [FUNC_W-1:0] FN_PREPEND   = 3'd1;
	localparam logic [FUNC_W-1:0] FN_POP_HEAD  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_POP_LAST  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_REMOVE_AT = 3'd4;
	localparam logic [FUNC_W-1:0] FN_READ_AT   = 3'd5;
	localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FETCH,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_ENDS,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load_item;
		logic exec;
		logic fetch;
		logic shift_rd;
		logic shift_wr;
		logic shift_end;
		logic read_ends;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic remove_ok;
		logic shift_more;
		logic out_free;
	} sts_t;

endpackage

### rtl/bounded_ring_deque.sv
// ----------------------------------------------------------------------------
// Bounded ring deque
// A ring of DEPTH slots holding up to capacity nonzero words, with insert and
// remove at either end, remove and read at a logical index, and clear.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Content
//  s_axis    in         s_tvalid / s_tready  one operation per transfer
//  m_axis    out        m_tvalid / m_tready  one result per operation
//  cfg       in         cfg_valid/cfg_ready  capacity register write
//
// After its transfer an operation passes execute, fetch and response before the
// input is free again; remove at adds a shift loop, one read and write pair per
// element behind the removed one through the single write port of the slot
// memory, and a read of both ends before the response.
// The result waits in an output register, so the next operation is taken and
// worked while a stalled result is held, up to its own response step.
// Reset clears the pointers, the count, the capacity (to 16) and the control
// state; the slot memory is not cleared, as no unwritten slot reaches a result.
// ----------------------------------------------------------------------------
module bounded_ring_deque
	import brd_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // data_word, position, zero pad
	input  logic [FUNC_W-1:0]    s_tuser,   // func
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // result_word, count, front_word,
	                                        // back_word, zero pad
	output logic                 m_tuser,   // accepted
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CAP_W-1:0]     cfg_data   // capacity
);

	cmd_t              cmd;
	sts_t              sts;
	logic [DATA_W-1:0] out_result;
	logic [CNT_W-1:0]  out_count;
	logic [DATA_W-1:0] out_front;
	logic [DATA_W-1:0] out_back;

	brd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	brd_dpath #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.in_func      (s_tuser),
		.in_word      (s_tdata[DATA_W-1:0]),
		.in_pos       (s_tdata[DATA_W +: POS_W]),
		.cmd          (cmd),
		.sts          (sts),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_result   (out_result),
		.out_accepted (m_tuser),
		.out_count    (out_count),
		.out_front    (out_front),
		.out_back     (out_back)
	);

	assign cfg_ready = 1'b1;
	assign m_tdata   = {3'b000, out_back, out_front, out_count, out_result};

endmodule

### rtl/brd_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded ring deque controller
// Sequences one operation at a time: execute, fetch, the shift loop of a
// remove, the read of both ends and the hand-off to the output register.
// ----------------------------------------------------------------------------
module brd_ctrl
	import brd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_FETCH;
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				if (sts.remove_ok) begin
					state_d = ST_SHIFT_RD;
				end else begin
					cmd.read_ends = 1'b1;
					state_d       = ST_RESP;
				end
			end
			ST_SHIFT_RD: begin
				if (sts.shift_more) begin
					cmd.shift_rd = 1'b1;
					state_d      = ST_SHIFT_WR;
				end else begin
					cmd.shift_end = 1'b1;
					state_d       = ST_ENDS;
				end
			end
			ST_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				state_d      = ST_SHIFT_RD;
			end
			ST_ENDS: begin
				cmd.read_ends = 1'b1;
				state_d       = ST_RESP;
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/brd_dpath.sv
// ----------------------------------------------------------------------------
// Bounded ring deque datapath
// Slot memory with one write and two registered read ports, ring pointers,
// capacity register, operation decode and the output register.
// ----------------------------------------------------------------------------
module brd_dpath
	import brd_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [CAP_W-1:0]  cfg_data,
	input  logic [FUNC_W-1:0] in_func,
	input  logic [DATA_W-1:0] in_word,
	input  logic [POS_W-1:0]  in_pos,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [DATA_W-1:0] out_result,
	output logic              out_accepted,
	output logic [CNT_W-1:0]  out_count,
	output logic [DATA_W-1:0] out_front,
	output logic [DATA_W-1:0] out_back
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int SW   = (WORD_WIDTH < DATA_W) ? WORD_WIDTH : DATA_W;
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
	localparam int PW   = (CW > POS_W) ? CW : POS_W;

	logic [SW-1:0] mem [DEPTH];

	logic [CAP_W-1:0]  cap_q;
	logic [AW-1:0]     front_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     j_q;
	logic [FUNC_W-1:0] func_q;
	logic [SW-1:0]     word_q;
	logic [POS_W-1:0]  pos_q;
	logic [SW-1:0]     res_q;
	logic              ok_q;
	logic [SW-1:0]     rd_a_q;
	logic [SW-1:0]     rd_b_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_result_q;
	logic              out_accepted_q;
	logic [CNT_W-1:0]  out_count_q;
	logic [DATA_W-1:0] out_front_q;
	logic [DATA_W-1:0] out_back_q;

	logic          is_insert;
	logic          is_extract;
	logic          full;
	logic          pos_ok;
	logic          ok;
	logic [CW-1:0] pos_c;
	logic [PW-1:0] pos_ext;
	logic [CW-1:0] la;
	logic [CW-1:0] lb;
	logic [AW-1:0] phys_a;
	logic [AW-1:0] phys_b;
	logic [AW-1:0] front_dec;
	logic [AW-1:0] front_inc;
	logic          we;
	logic [AW-1:0] wa;
	logic [SW-1:0] wd;
	logic          re_a;
	logic          re_b;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] l);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(l);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign is_insert  = (func_q == FN_APPEND) || (func_q == FN_PREPEND);
	assign is_extract = (func_q == FN_POP_HEAD) || (func_q == FN_POP_LAST)
		|| (func_q == FN_REMOVE_AT) || (func_q == FN_READ_AT);
	assign full    = (CMPW'(count_q) >= CMPW'(cap_q)) || (count_q >= CW'(DEPTH));
	assign pos_ext = PW'(pos_q);
	assign pos_c   = pos_ext[CW-1:0];
	assign pos_ok  = pos_ext < PW'(count_q);

	always_comb begin
		case (func_q)
			FN_APPEND, FN_PREPEND:   ok = (word_q != '0) && !full;
			FN_POP_HEAD, FN_POP_LAST: ok = (count_q != '0);
			FN_REMOVE_AT, FN_READ_AT: ok = pos_ok;
			FN_CLEAR:                ok = 1'b1;
			default:                 ok = 1'b0;
		endcase
	end

	always_comb begin
		la = '0;
		if (cmd.exec) begin
			case (func_q)
				FN_APPEND:               la = count_q;
				FN_POP_LAST:             la = count_q - 1'b1;
				FN_REMOVE_AT, FN_READ_AT: la = pos_c;
				default:                 la = '0;
			endcase
		end else if (cmd.shift_rd) begin
			la = j_q + 1'b1;
		end else if (cmd.shift_wr) begin
			la = j_q;
		end
	end

	assign lb        = count_q - 1'b1;
	assign phys_a    = phys(front_q, la);
	assign phys_b    = phys(front_q, lb);
	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;

	assign we   = (cmd.exec && ok && is_insert) || cmd.shift_wr;
	assign wa   = (cmd.exec && (func_q == FN_PREPEND)) ? front_dec : phys_a;
	assign wd   = cmd.exec ? word_q : rd_a_q;
	assign re_a = (cmd.exec && ok && is_extract) || cmd.shift_rd || cmd.read_ends;
	assign re_b = cmd.read_ends && (count_q != '0);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re_a) begin
			rd_a_q <= mem[cmd.read_ends ? front_q : phys_a];
		end
		if (re_b) begin
			rd_b_q <= mem[phys_b];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			func_q <= in_func;
			word_q <= in_word[SW-1:0];
			pos_q  <= in_pos;
		end
		if (cmd.exec) begin
			ok_q  <= ok;
			res_q <= (ok && is_insert) ? word_q : '0;
			j_q   <= pos_c;
		end else if (cmd.fetch && ok_q && is_extract) begin
			res_q <= rd_a_q;
		end else if (cmd.shift_wr) begin
			j_q <= j_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			front_q <= '0;
			count_q <= '0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (cmd.exec && ok) begin
				case (func_q)
					FN_APPEND: begin
						count_q <= count_q + 1'b1;
					end
					FN_PREPEND: begin
						front_q <= front_dec;
						count_q <= count_q + 1'b1;
					end
					FN_POP_HEAD: begin
						front_q <= front_inc;
						count_q <= count_q - 1'b1;
					end
					FN_POP_LAST: begin
						count_q <= count_q - 1'b1;
					end
					FN_CLEAR: begin
						front_q <= '0;
						count_q <= '0;
					end
					default: begin
						count_q <= count_q;
					end
				endcase
			end else if (cmd.shift_end) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign sts.remove_ok  = ok_q && (func_q == FN_REMOVE_AT);
	assign sts.shift_more = ((CW+1)'(j_q) + 1'b1) < (CW+1)'(count_q);
	assign sts.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_result_q   <= DATA_W'(res_q);
			out_accepted_q <= ok_q;
			out_count_q    <= CNT_W'(count_q);
			out_front_q    <= (count_q != '0) ? DATA_W'(rd_a_q) : '0;
			out_back_q     <= (count_q != '0) ? DATA_W'(rd_b_q) : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_result   = out_result_q;
	assign out_accepted = out_accepted_q;
	assign out_count    = out_count_q;
	assign out_front    = out_front_q;
	assign out_back     = out_back_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("live count exceeds depth");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		front_q <= AW'(DEPTH - 1))
		else $error("front index outside the ring");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && ok && is_insert) |=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not raise the count by one");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result loaded over an untaken transfer");
`endif

endmodule

### bench/tb_bounded_ring_deque.sv
// ----------------------------------------------------------------------------
// Bounded ring deque testbench
// Drives operations into the deque over its input stream and checks every
// result against a predictor that keeps its own copy of the ring, the count
// and the capacity. A directed opening covers the empty, full, refused and
// out-of-range cases. Randomized phases then follow, each with a capacity
// setting and a pattern of source gaps and sink stalls; both repeat across phases.
// ----------------------------------------------------------------------------
module tb_bounded_ring_deque;
	import brd_pkg::*;

	localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
	localparam int NUM_PHASES   = 8;
	localparam int PHASE_OPS    = 130;
	localparam int CFG_SETTLE   = 40;
	localparam int DRAIN_CYCLES = 60;
	localparam int LIMIT_CYCLES = 600000;

	typedef struct packed {
		logic [DATA_W-1:0] word;
		logic              ok;
		logic [CNT_W-1:0]  cnt;
		logic [DATA_W-1:0] front_w;
		logic [DATA_W-1:0] back_w;
	} deque_result_t;

	class deque_scoreboard;
		logic [DATA_W-1:0] ring[DEPTH_DEF];
		int unsigned       head_idx;
		int unsigned       live;
		logic [CAP_W-1:0]  cap_reg;
		deque_result_t     expected_q[$];
		int unsigned       error_count;

		function new();
			foreach (ring[i])
				ring[i] = '0;
			head_idx = 0;
			live = 0;
			cap_reg = CAP_RESET;
			error_count = 0;
		endfunction

		function int unsigned phys(input int unsigned l);
			return (head_idx + l) % DEPTH_DEF;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void set_capacity(input logic [CAP_W-1:0] v);
			cap_reg = v;
		endfunction

		function void note_op(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] word,
		                      input logic [POS_W-1:0] pos);
			deque_result_t r;
			int unsigned   lim;
			int unsigned   j;
			lim = (cap_reg < DEPTH_DEF) ? cap_reg : DEPTH_DEF;
			r = '0;
			case (fn)
				FN_APPEND: begin
					if (word != '0 && live < lim) begin
						ring[phys(live)] = word;
						live++;
						r.word = word;
						r.ok = 1'b1;
					end
				end
				FN_PREPEND: begin
					if (word != '0 && live < lim) begin
						head_idx = (head_idx + DEPTH_DEF - 1) % DEPTH_DEF;
						ring[head_idx] = word;
						live++;
						r.word = word;
						r.ok = 1'b1;
					end
				end
				FN_POP_HEAD: begin
					if (live != 0) begin
						r.word = ring[head_idx];
						ring[head_idx] = '0;
						head_idx = (head_idx + 1) % DEPTH_DEF;
						live--;
						r.ok = 1'b1;
					end
				end
				FN_POP_LAST: begin
					if (live != 0) begin
						r.word = ring[phys(live - 1)];
						ring[phys(live - 1)] = '0;
						live--;
						r.ok = 1'b1;
					end
				end
				FN_REMOVE_AT: begin
					if (pos < live) begin
						r.word = ring[phys(pos)];
						for (j = pos; j + 1 < live; j++)
							ring[phys(j)] = ring[phys(j + 1)];
						ring[phys(live - 1)] = '0;
						live--;
						r.ok = 1'b1;
					end
				end
				FN_READ_AT: begin
					if (pos < live) begin
						r.word = ring[phys(pos)];
						r.ok = 1'b1;
					end
				end
				FN_CLEAR: begin
					head_idx = 0;
					live = 0;
					r.ok = 1'b1;
				end
				default: begin
				end
			endcase
			r.cnt = live[CNT_W-1:0];
			if (live != 0) begin
				r.front_w = ring[head_idx];
				r.back_w = ring[phys(live - 1)];
			end
			expected_q.push_back(r);
		endfunction

		task report_mismatch(input string what, input logic [DATA_W-1:0] got,
		                     input logic [DATA_W-1:0] want);
			$display("mismatch %s: got %h, expected %h", what, got, want);
			error_count++;
		endtask

		task check_result(input logic [M_TDATA_W-1:0] tdata, input logic tuser);
			deque_result_t e;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result transfer", tdata[DATA_W-1:0], '0);
			end else begin
				e = expected_q.pop_front();
				if (tdata[31:0] !== e.word)
					report_mismatch("result_word", tdata[31:0], e.word);
				if (tuser !== e.ok)
					report_mismatch("accepted", {31'd0, tuser}, {31'd0, e.ok});
				if (tdata[36:32] !== e.cnt)
					report_mismatch("count", {27'd0, tdata[36:32]}, {27'd0, e.cnt});
				if (tdata[68:37] !== e.front_w)
					report_mismatch("front_word", tdata[68:37], e.front_w);
				if (tdata[100:69] !== e.back_w)
					report_mismatch("back_word", tdata[100:69], e.back_w);
			end
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [FUNC_W-1:0]    s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CAP_W-1:0]     cfg_data;

	deque_scoreboard sb;
	int unsigned     idle_mode;
	int unsigned     cycle_count;

	bounded_ring_deque DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function int unsigned source_gap_pct();
		return (idle_mode == 1) ? 69 : (idle_mode == 3) ? 6 : 0;
	endfunction

	function int unsigned sink_stall_pct();
		return (idle_mode == 2) ? 69 : (idle_mode == 3) ? 6 : 0;
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		m_tready <= ($urandom_range(99) >= sink_stall_pct());
	end

	task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] word,
	                       input logic [POS_W-1:0] pos);
		if (source_gap_pct() != 0 && $urandom_range(99) < source_gap_pct()) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < source_gap_pct());
		end
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {{(S_TDATA_W - DATA_W - POS_W){1'b0}}, pos, word};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_op(fn, word, pos);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_capacity(v);
	endtask

	task automatic send_random_op();
		logic [FUNC_W-1:0] fn;
		logic [DATA_W-1:0] word;
		logic [POS_W-1:0]  pos;
		int unsigned       r;
		r = $urandom_range(99);
		if (r < 30)
			fn = FN_APPEND;
		else if (r < 50)
			fn = FN_PREPEND;
		else if (r < 60)
			fn = FN_POP_HEAD;
		else if (r < 68)
			fn = FN_POP_LAST;
		else if (r < 78)
			fn = FN_REMOVE_AT;
		else if (r < 94)
			fn = FN_READ_AT;
		else if (r < 97)
			fn = FN_CLEAR;
		else
			fn = FN_UNUSED;
		r = $urandom_range(19);
		if (r == 0)
			word = '0;
		else if (r == 1)
			word = '1;
		else
			word = $urandom;
		if (sb.live == 0 || $urandom_range(4) == 0)
			pos = $urandom_range(15);
		else
			pos = $urandom_range(sb.live - 1);
		send_op(fn, word, pos);
	endtask

	initial begin
		logic [CAP_W-1:0] phase_cap[NUM_PHASES];
		int               p;
		int               n;
		phase_cap = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd16, 5'd0, 5'd9, 5'd16};
		sb = new();
		idle_mode = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = FN_APPEND;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		write_capacity(5'd16);
		send_op(FN_POP_HEAD, '0, 4'd0);
		send_op(FN_POP_LAST, '0, 4'd0);
		send_op(FN_READ_AT, '0, 4'd0);
		send_op(FN_REMOVE_AT, '0, 4'd0);
		send_op(FN_UNUSED, 32'hDEAD_BEEF, 4'd15);
		send_op(FN_APPEND, '0, 4'd0);
		send_op(FN_PREPEND, '0, 4'd0);
		send_op(FN_APPEND, 32'hFFFF_FFFF, 4'd0);
		send_op(FN_PREPEND, 32'h0000_0001, 4'd0);
		send_op(FN_APPEND, 32'h8000_0000, 4'd0);
		send_op(FN_PREPEND, 32'h5555_5555, 4'd0);
		send_op(FN_READ_AT, '0, 4'd3);
		send_op(FN_READ_AT, '0, 4'd4);
		send_op(FN_REMOVE_AT, '0, 4'd15);
		send_op(FN_REMOVE_AT, '0, 4'd1);
		send_op(FN_POP_LAST, '0, 4'd0);
		send_op(FN_POP_HEAD, '0, 4'd0);
		send_op(FN_APPEND, 32'h1234_5678, 4'd0);

		// Two live words, then a limit of one leaves the deque over its capacity.
		write_capacity(5'd1);
		send_op(FN_APPEND, 32'h0BAD_F00D, 4'd0);
		send_op(FN_POP_HEAD, '0, 4'd0);
		send_op(FN_PREPEND, 32'h0000_0002, 4'd0);
		send_op(FN_CLEAR, '0, 4'd0);
		send_op(FN_APPEND, 32'hCAFE_0001, 4'd0);
		send_op(FN_APPEND, 32'hCAFE_0002, 4'd0);
		write_capacity(5'd0);
		send_op(FN_PREPEND, 32'h7FFF_FFFF, 4'd0);

		for (p = 0; p < NUM_PHASES; p++) begin
			write_capacity(phase_cap[p]);
			idle_mode = p % 4;
			for (n = 0; n < PHASE_OPS; n++)
				send_random_op();
		end

		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

### bounded_ring_deque.f
rtl/brd_pkg.sv
rtl/brd_ctrl.sv
rtl/brd_dpath.sv
rtl/bounded_ring_deque.sv
bench/tb_bounded_ring_deque.sv
